@@ hw/rtl/pkvsl_pkg.sv @@
package pkvsl_pkg;

   localparam int STORE_WORDS     = 1024;
   localparam int MAX_KEY_WORDS   = 16;
   localparam int MAX_VALUE_WORDS = 64;

   // A 12-bit byte count spans at most this many words.
   localparam int REC_WORDS_MAX = (4095 + 3) / 4;

   localparam int ADDR_W  = $clog2(STORE_WORDS);
   localparam int KEY_AW  = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
   localparam int POS_W   = $clog2(STORE_WORDS + 2 * REC_WORDS_MAX + 2);
   localparam int WCNT_W  = $clog2(REC_WORDS_MAX + 1);
   localparam int CNT_MAX = (MAX_KEY_WORDS > MAX_VALUE_WORDS) ? MAX_KEY_WORDS
                                                              : MAX_VALUE_WORDS;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   localparam logic [1:0] ACT_STORE_WRITE = 2'd0;
   localparam logic [1:0] ACT_KEY_WRITE   = 2'd1;
   localparam logic [1:0] ACT_LOOKUP      = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  word_index;
      logic [31:0] data_word;
      logic [31:0] query_info;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  value_type;
      logic [11:0] value_bytes;
      logic [31:0] value_word;
      logic        truncated;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HDR_RD,
      ST_HDR_CHK,
      ST_KEY_RD,
      ST_KEY_CHK,
      ST_VAL_RD,
      ST_VAL_OUT,
      ST_MISS
   } state_type;

   // Keeps the low (nbytes mod 4) bytes of a word, or all bytes when that is zero.
   function automatic logic [31:0] tail_mask(input logic [1:0] low_bits);
      logic [31:0] m;
      case (low_bits)
         2'd1:    m = 32'h0000_00FF;
         2'd2:    m = 32'h0000_FFFF;
         2'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

@@ hw/rtl/pkvsl_ram.sv @@
module pkvsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/pkvsl_scan.sv @@
module pkvsl_scan (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pkvsl_pkg::req_type                 req_payload,
   input  logic [9:0]                         scan_start,
   output logic                               st_wr_en,
   output logic [pkvsl_pkg::ADDR_W-1:0]       st_wr_addr,
   output logic [31:0]                        st_wr_data,
   output logic [pkvsl_pkg::ADDR_W-1:0]       st_rd_addr,
   input  logic [31:0]                        st_rd_data,
   output logic                               key_wr_en,
   output logic [pkvsl_pkg::KEY_AW-1:0]       key_wr_addr,
   output logic [31:0]                        key_wr_data,
   output logic [pkvsl_pkg::KEY_AW-1:0]       key_rd_addr,
   input  logic [31:0]                        key_rd_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pkvsl_pkg::rsp_type                 rsp_payload
);

   localparam int POS_W  = pkvsl_pkg::POS_W;
   localparam int CNT_W  = pkvsl_pkg::CNT_W;
   localparam int WCNT_W = pkvsl_pkg::WCNT_W;
   localparam int ADDR_W = pkvsl_pkg::ADDR_W;

   pkvsl_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [3:0]           qtype_ff, qtype_in;
   logic [11:0]          qsize_ff, qsize_in;
   logic [3:0]           vtype_ff, vtype_in;
   logic [11:0]          vsize_ff, vsize_in;
   logic [WCNT_W-1:0]    kw_ff, kw_in;
   logic [WCNT_W-1:0]    vw_ff, vw_in;
   logic [CNT_W-1:0]     nwords_ff, nwords_in;
   logic                 trunc_ff, trunc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pkvsl_pkg::rsp_type   rsp_ff, rsp_in;

   logic              accept;
   logic              slot_free;
   logic [POS_W-1:0]  rd_idx;
   logic              rd_oob;
   logic [31:0]       rd_word;
   logic [3:0]        h_ktype;
   logic [11:0]       h_ksize;
   logic [3:0]        h_vtype;
   logic [11:0]       h_vsize;
   logic [WCNT_W-1:0] h_kw;
   logic [WCNT_W-1:0] h_vw;
   logic [WCNT_W-1:0] q_words;
   logic [31:0]       key_mask;
   logic              key_last;
   logic              key_diff;
   logic              val_tail;
   logic              val_last;
   logic [31:0]       val_word;

   assign accept    = req_valid && (state_ff == pkvsl_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // The read address follows the scan position plus the word counter, so the
   // registered read data stays valid while a result waits for the output.
   assign rd_idx  = pos_ff + POS_W'(cnt_ff);
   assign rd_oob  = rd_idx >= POS_W'(pkvsl_pkg::STORE_WORDS);
   assign rd_word = rd_oob ? 32'd0 : st_rd_data;

   assign h_ktype = st_rd_data[31:28];
   assign h_ksize = st_rd_data[27:16];
   assign h_vtype = st_rd_data[15:12];
   assign h_vsize = st_rd_data[11:0];
   assign h_kw    = WCNT_W'(({2'b00, h_ksize} + 14'd3) >> 2);
   assign h_vw    = WCNT_W'(({2'b00, h_vsize} + 14'd3) >> 2);
   assign q_words = WCNT_W'(({2'b00, req_payload.query_info[27:16]} + 14'd3) >> 2);

   assign key_last = (WCNT_W'(cnt_ff) + WCNT_W'(1)) == kw_ff;
   assign key_mask = key_last ? pkvsl_pkg::tail_mask(qsize_ff[1:0]) : 32'hFFFF_FFFF;
   assign key_diff = ((rd_word ^ key_rd_data) & key_mask) != 32'd0;

   assign val_tail = (WCNT_W'(cnt_ff) + WCNT_W'(1)) == vw_ff;
   assign val_last = (cnt_ff + CNT_W'(1)) == nwords_ff;
   assign val_word = val_tail ? (rd_word & pkvsl_pkg::tail_mask(vsize_ff[1:0])) : rd_word;

   // Next state and sequencer registers.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      qtype_in     = qtype_ff;
      qsize_in     = qsize_ff;
      vtype_in     = vtype_ff;
      vsize_in     = vsize_ff;
      kw_in        = kw_ff;
      vw_in        = vw_ff;
      nwords_in    = nwords_ff;
      trunc_in     = trunc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         pkvsl_pkg::ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(pkvsl_pkg::STORE_WORDS - 1)) begin
               state_in = pkvsl_pkg::ST_IDLE;
            end
         end
         pkvsl_pkg::ST_IDLE: begin
            if (accept && req_payload.action == pkvsl_pkg::ACT_LOOKUP) begin
               qtype_in = req_payload.query_info[31:28];
               qsize_in = req_payload.query_info[27:16];
               pos_in   = POS_W'(scan_start);
               cnt_in   = '0;
               if (q_words > WCNT_W'(pkvsl_pkg::MAX_KEY_WORDS)) begin
                  state_in = pkvsl_pkg::ST_MISS;
               end else begin
                  state_in = pkvsl_pkg::ST_HDR_RD;
               end
            end
         end
         pkvsl_pkg::ST_HDR_RD: begin
            state_in = rd_oob ? pkvsl_pkg::ST_MISS : pkvsl_pkg::ST_HDR_CHK;
         end
         pkvsl_pkg::ST_HDR_CHK: begin
            if (st_rd_data == 32'd0) begin
               state_in = pkvsl_pkg::ST_MISS;
            end else if (h_ksize == 12'd0 || h_vsize == 12'd0) begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = pkvsl_pkg::ST_HDR_RD;
            end else if (h_ktype != qtype_ff || h_ksize != qsize_ff) begin
               pos_in   = pos_ff + POS_W'(1) + POS_W'(h_kw) + POS_W'(h_vw);
               state_in = pkvsl_pkg::ST_HDR_RD;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               vtype_in = h_vtype;
               vsize_in = h_vsize;
               kw_in    = h_kw;
               vw_in    = h_vw;
               state_in = pkvsl_pkg::ST_KEY_RD;
            end
         end
         pkvsl_pkg::ST_KEY_RD: begin
            state_in = pkvsl_pkg::ST_KEY_CHK;
         end
         pkvsl_pkg::ST_KEY_CHK: begin
            if (key_diff) begin
               pos_in   = pos_ff + POS_W'(kw_ff) + POS_W'(vw_ff);
               cnt_in   = '0;
               state_in = pkvsl_pkg::ST_HDR_RD;
            end else if (key_last) begin
               pos_in   = pos_ff + POS_W'(kw_ff);
               cnt_in   = '0;
               if (vw_ff > WCNT_W'(pkvsl_pkg::MAX_VALUE_WORDS)) begin
                  nwords_in = CNT_W'(pkvsl_pkg::MAX_VALUE_WORDS);
                  trunc_in  = 1'b1;
               end else begin
                  nwords_in = CNT_W'(vw_ff);
                  trunc_in  = 1'b0;
               end
               state_in = pkvsl_pkg::ST_VAL_RD;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = pkvsl_pkg::ST_KEY_RD;
            end
         end
         pkvsl_pkg::ST_VAL_RD: begin
            state_in = pkvsl_pkg::ST_VAL_OUT;
         end
         pkvsl_pkg::ST_VAL_OUT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.value_type  = vtype_ff;
               rsp_in.value_bytes = vsize_ff;
               rsp_in.value_word  = val_word;
               rsp_in.truncated   = trunc_ff;
               rsp_in.last        = val_last;
               if (val_last) begin
                  state_in = pkvsl_pkg::ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = pkvsl_pkg::ST_VAL_RD;
               end
            end
         end
         pkvsl_pkg::ST_MISS: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = 1'b0;
               rsp_in.value_type  = 4'd0;
               rsp_in.value_bytes = 12'd0;
               rsp_in.value_word  = 32'd0;
               rsp_in.truncated   = 1'b0;
               rsp_in.last        = 1'b1;
               state_in           = pkvsl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pkvsl_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory and handshake controls.
   always_comb begin
      req_stall   = state_ff != pkvsl_pkg::ST_IDLE;
      st_wr_en    = 1'b0;
      st_wr_addr  = ADDR_W'(req_payload.word_index);
      st_wr_data  = req_payload.data_word;
      key_wr_en   = 1'b0;
      key_wr_addr = pkvsl_pkg::KEY_AW'(req_payload.word_index);
      key_wr_data = req_payload.data_word;
      st_rd_addr  = rd_idx[ADDR_W-1:0];
      key_rd_addr = pkvsl_pkg::KEY_AW'(cnt_ff);
      case (state_ff)
         pkvsl_pkg::ST_CLEAR: begin
            st_wr_en   = 1'b1;
            st_wr_addr = clr_ff;
            st_wr_data = 32'd0;
         end
         pkvsl_pkg::ST_IDLE: begin
            if (accept && req_payload.action == pkvsl_pkg::ACT_STORE_WRITE) begin
               st_wr_en = int'(req_payload.word_index) < pkvsl_pkg::STORE_WORDS;
            end
            if (accept && req_payload.action == pkvsl_pkg::ACT_KEY_WRITE) begin
               key_wr_en = int'(req_payload.word_index) < pkvsl_pkg::MAX_KEY_WORDS;
            end
         end
         default: begin
            st_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pkvsl_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      qtype_ff  <= qtype_in;
      qsize_ff  <= qsize_in;
      vtype_ff  <= vtype_in;
      vsize_ff  <= vsize_in;
      kw_ff     <= kw_in;
      vw_ff     <= vw_in;
      nwords_ff <= nwords_in;
      trunc_ff  <= trunc_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hw/rtl/packed_key_value_scan_lookup_top.sv @@
// Packed key/value record store with a linear lookup scan.
// Request channel (req_valid, req_stall, req_payload): each item writes a
// store word, writes a query key word, or starts a lookup with the key type
// and size in query_info. Result channel (rsp_valid, rsp_stall, rsp_payload):
// a lookup returns one item per value word on a hit, at most 64, or a single
// not-found item, with last set on its final item. Writes return nothing.
// Configuration port (csr_valid, csr_ready, csr_data) sets scan_start; it is
// always ready and is meant to be written while no lookup is in flight.
// Store and key writes are taken one per cycle while idle. A lookup holds
// req_stall high for its whole scan, since every step is a read of the store
// memory through its registered read port. After the last key word compare,
// the first result passes through ST_VAL_RD and ST_VAL_OUT into the result
// register.
// Reset clears scan_start and then runs a clearing pass that writes zero to
// all 1024 store words, one per cycle; req_stall stays high throughout the
// pass. The key buffer is not cleared. When the receiver stalls, the result
// register holds its item and the scan waits before the next value word.
module packed_key_value_scan_lookup_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pkvsl_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pkvsl_pkg::rsp_type rsp_payload,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [9:0]         csr_data
);

   logic [9:0]                     scan_start_ff;
   logic                           st_wr_en;
   logic [pkvsl_pkg::ADDR_W-1:0]   st_wr_addr;
   logic [31:0]                    st_wr_data;
   logic [pkvsl_pkg::ADDR_W-1:0]   st_rd_addr;
   logic [31:0]                    st_rd_data;
   logic                           key_wr_en;
   logic [pkvsl_pkg::KEY_AW-1:0]   key_wr_addr;
   logic [31:0]                    key_wr_data;
   logic [pkvsl_pkg::KEY_AW-1:0]   key_rd_addr;
   logic [31:0]                    key_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_start_ff <= 10'd0;
      end else if (csr_valid && csr_ready) begin
         scan_start_ff <= csr_data;
      end
   end

   pkvsl_ram #(
      .WIDTH (32),
      .DEPTH (pkvsl_pkg::STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   pkvsl_ram #(
      .WIDTH (32),
      .DEPTH (pkvsl_pkg::MAX_KEY_WORDS)
   ) u_key_buf (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   pkvsl_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .scan_start  (scan_start_ff),
      .st_wr_en    (st_wr_en),
      .st_wr_addr  (st_wr_addr),
      .st_wr_data  (st_wr_data),
      .st_rd_addr  (st_rd_addr),
      .st_rd_data  (st_rd_data),
      .key_wr_en   (key_wr_en),
      .key_wr_addr (key_wr_addr),
      .key_wr_data (key_wr_data),
      .key_rd_addr (key_rd_addr),
      .key_rd_data (key_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
